// ----- rtl/coverage_span_buffer_defines.svh -----
// Assertion macros shared by the coverage span buffer RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef COVERAGE_SPAN_BUFFER_DEFINES_SVH
`define COVERAGE_SPAN_BUFFER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SB_ASSERT(lbl, prop, msg) lbl: assert property (prop) else $error(msg);
`define SB_ASSERT_CLK(lbl, prop, msg) \
    `SB_ASSERT(lbl, @(posedge clk) disable iff (!rst_n) prop, msg)
`else
`define SB_ASSERT(lbl, prop, msg)
`define SB_ASSERT_CLK(lbl, prop, msg)
`endif
`endif

// ----- rtl/spanbuf_pkg.sv -----
// Package for the coverage span buffer: sizes, command and register codes,
// datapath operation codes and the controller status struct. No dependencies.
`timescale 1ns / 1ps

package spanbuf_pkg;

    localparam int MAX_LINES     = 1024;
    localparam int MAX_INTERVALS = 64;
    localparam int COORD_BITS    = 12;

    localparam int CFG_W  = 11;
    localparam int LIDX_W = 10;
    localparam int LINE_W = $clog2(MAX_LINES);
    localparam int SLOT_W = $clog2(MAX_INTERVALS);
    localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
    localparam int NL_W   = ($clog2(MAX_LINES + 1) > CFG_W) ? $clog2(MAX_LINES + 1) : CFG_W;
    localparam int IADDR_W = LINE_W + SLOT_W;

    localparam logic [CFG_W-1:0] OPEN_MAX = CFG_W'(MAX_LINES);

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_TEST   = 2'd1;
    localparam logic [1:0] CMD_INSERT = 2'd2;

    localparam logic [1:0] REG_SCREEN_LEFT  = 2'd0;
    localparam logic [1:0] REG_SCREEN_RIGHT = 2'd1;
    localparam logic [1:0] REG_LINE_COUNT   = 2'd2;

    localparam logic [CFG_W-1:0] RST_SCREEN_LEFT  = 11'd0;
    localparam logic [CFG_W-1:0] RST_SCREEN_RIGHT = 11'd639;
    localparam logic [CFG_W-1:0] RST_LINE_COUNT   = 11'd480;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic [4:0] {
        DP_NONE,
        DP_ACCEPT,
        DP_INIT,
        DP_CLR,
        DP_LRD,
        DP_LCAP,
        DP_IRD,
        DP_IEV,
        DP_TEV,
        DP_BEV,
        DP_WRR,
        DP_WRRB,
        DP_FIN_CLR,
        DP_FIN_OTHER,
        DP_FIN_NOUSE,
        DP_FIN_REV,
        DP_FIN_WALK
    } dp_op_t;

    typedef enum logic [2:0] {
        EV_KEEP,
        EV_STOP,
        EV_DROP,
        EV_LEFT,
        EV_RIGHT,
        EV_SPLIT,
        EV_OVF
    } ev_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       in_use;
        logic       span_rev;
        logic       init_last;
        logic       clr_end;
        logic       j_eq_cnt;
        logic       j_eq_o;
        logic       o1_eq_j;
        ev_t        ev;
    } sb_status_t;

endpackage

// ----- rtl/spanbuf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module spanbuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/spanbuf_ctrl.sv -----
// Controller state machine of the coverage span buffer.
// Depends on spanbuf_pkg; drives datapath operations from datapath status.
`timescale 1ns / 1ps

module spanbuf_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  spanbuf_pkg::sb_status_t status,
    output spanbuf_pkg::dp_op_t     op,
    output logic                    busy
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISP,
        S_CLR,
        S_LCAP,
        S_REV,
        S_IRD,
        S_IEV,
        S_TRD,
        S_TEV,
        S_BRD,
        S_BEV,
        S_WRR,
        S_WRRB,
        S_END
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        op         = spanbuf_pkg::DP_NONE;
        unique case (state_reg)
            S_INIT:
            begin
                op = spanbuf_pkg::DP_INIT;
                if (status.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op         = spanbuf_pkg::DP_ACCEPT;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (status.cmd == spanbuf_pkg::CMD_CLEAR)
                begin
                    state_next = S_CLR;
                end
                else if (status.cmd == spanbuf_pkg::CMD_TEST ||
                         status.cmd == spanbuf_pkg::CMD_INSERT)
                begin
                    if (status.in_use)
                    begin
                        op         = spanbuf_pkg::DP_LRD;
                        state_next = S_LCAP;
                    end
                    else
                    begin
                        op         = spanbuf_pkg::DP_FIN_NOUSE;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    op         = spanbuf_pkg::DP_FIN_OTHER;
                    state_next = S_IDLE;
                end
            end
            S_CLR:
            begin
                if (status.clr_end)
                begin
                    op         = spanbuf_pkg::DP_FIN_CLR;
                    state_next = S_IDLE;
                end
                else
                begin
                    op = spanbuf_pkg::DP_CLR;
                end
            end
            S_LCAP:
            begin
                op         = spanbuf_pkg::DP_LCAP;
                state_next = status.span_rev ? S_REV : S_IRD;
            end
            S_REV:
            begin
                op         = spanbuf_pkg::DP_FIN_REV;
                state_next = S_IDLE;
            end
            S_IRD:
            begin
                if (status.j_eq_cnt)
                begin
                    state_next = S_END;
                end
                else
                begin
                    op         = spanbuf_pkg::DP_IRD;
                    state_next = S_IEV;
                end
            end
            S_IEV:
            begin
                op = spanbuf_pkg::DP_IEV;
                if (status.cmd == spanbuf_pkg::CMD_TEST)
                begin
                    state_next = (status.ev == spanbuf_pkg::EV_KEEP) ? S_IRD : S_END;
                end
                else
                begin
                    unique case (status.ev)
                        spanbuf_pkg::EV_KEEP,
                        spanbuf_pkg::EV_DROP,
                        spanbuf_pkg::EV_LEFT,
                        spanbuf_pkg::EV_RIGHT: state_next = S_IRD;
                        spanbuf_pkg::EV_STOP,
                        spanbuf_pkg::EV_OVF:   state_next = status.j_eq_o ? S_END : S_TRD;
                        spanbuf_pkg::EV_SPLIT: state_next = status.j_eq_o ? S_BRD : S_WRR;
                        default:               state_next = S_END;
                    endcase
                end
            end
            S_TRD:
            begin
                if (status.j_eq_cnt)
                begin
                    state_next = S_END;
                end
                else
                begin
                    op         = spanbuf_pkg::DP_IRD;
                    state_next = S_TEV;
                end
            end
            S_TEV:
            begin
                op         = spanbuf_pkg::DP_TEV;
                state_next = S_TRD;
            end
            S_BRD:
            begin
                if (status.j_eq_o)
                begin
                    state_next = S_WRRB;
                end
                else
                begin
                    op         = spanbuf_pkg::DP_IRD;
                    state_next = S_BEV;
                end
            end
            S_BEV:
            begin
                op         = spanbuf_pkg::DP_BEV;
                state_next = S_BRD;
            end
            S_WRR:
            begin
                op         = spanbuf_pkg::DP_WRR;
                state_next = status.o1_eq_j ? S_END : S_TRD;
            end
            S_WRRB:
            begin
                op         = spanbuf_pkg::DP_WRRB;
                state_next = S_END;
            end
            S_END:
            begin
                op         = spanbuf_pkg::DP_FIN_WALK;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- rtl/spanbuf_dp.sv -----
// Datapath of the coverage span buffer: configuration, line and interval RAMs,
// list walk registers and result registers. Depends on spanbuf_pkg, spanbuf_ram.
`timescale 1ns / 1ps

module spanbuf_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  spanbuf_pkg::dp_op_t                   op,
    output spanbuf_pkg::sb_status_t               status,
    input  logic                                  cfg_we,
    input  logic [1:0]                            cfg_index,
    input  logic [spanbuf_pkg::CFG_W-1:0]         cfg_data,
    input  logic [1:0]                            cmd,
    input  logic [spanbuf_pkg::LIDX_W-1:0]        line_index,
    input  logic signed [spanbuf_pkg::COORD_BITS-1:0] span_start,
    input  logic signed [spanbuf_pkg::COORD_BITS-1:0] span_end,
    output logic                                  done,
    output logic                                  visible,
    output logic                                  line_now_full,
    output logic [spanbuf_pkg::CFG_W-1:0]         lines_not_full,
    output logic                                  overflow
);

    localparam int CW = spanbuf_pkg::CNT_W;
    localparam int XW = spanbuf_pkg::COORD_BITS;
    localparam int NW = spanbuf_pkg::NL_W;
    localparam int LW = spanbuf_pkg::LINE_W;
    localparam int SW = spanbuf_pkg::SLOT_W;

    logic [spanbuf_pkg::CFG_W-1:0] left_reg;
    logic [spanbuf_pkg::CFG_W-1:0] right_reg;
    logic [spanbuf_pkg::CFG_W-1:0] lcount_reg;
    logic [NW-1:0]                 open_reg;
    logic [NW-1:0]                 k_reg;
    logic                          done_reg;

    logic [1:0]                    cmd_reg;
    logic [spanbuf_pkg::LIDX_W-1:0] y_reg;
    spanbuf_pkg::coord_t           a_reg;
    spanbuf_pkg::coord_t           b_reg;
    spanbuf_pkg::coord_t           rf_reg;
    spanbuf_pkg::coord_t           rl_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [CW-1:0]                 j_reg;
    logic [CW-1:0]                 o_reg;
    logic                          full_reg;
    logic                          vis_reg;
    logic                          ovf_reg;
    logic                          res_vis_reg;
    logic                          res_full_reg;
    logic [NW-1:0]                 res_count_reg;
    logic                          res_ovf_reg;

    logic [NW-1:0]                 n_use;
    logic [NW-1:0]                 lc_ext;
    logic                          bounds_ok;
    logic [LW-1:0]                 y_line;

    logic                          line_we;
    logic [LW-1:0]                 line_waddr;
    logic [CW:0]                   line_wdata;
    logic [CW:0]                   line_rdata;

    logic                          int_we;
    logic [LW-1:0]                 int_wline;
    logic [SW-1:0]                 int_wslot;
    spanbuf_pkg::coord_t           int_wf;
    spanbuf_pkg::coord_t           int_wl;
    logic [2*XW-1:0]               int_rdata;

    spanbuf_pkg::coord_t           f_val;
    spanbuf_pkg::coord_t           l_val;
    spanbuf_pkg::coord_t           a_m1;
    spanbuf_pkg::coord_t           b_p1;
    logic                          stop_c;
    logic                          below_c;
    logic                          inner_c;
    logic                          strad_c;
    logic [CW:0]                   room;
    logic                          ovf_need;
    spanbuf_pkg::ev_t              ev;
    logic [CW-1:0]                 j_p1;
    logic [CW-1:0]                 o_p1;
    logic [CW-1:0]                 new_cnt;
    logic                          is_insert;
    logic                          full_new;
    logic [NW-1:0]                 open_after;

    assign lc_ext    = NW'(lcount_reg);
    assign n_use     = (lc_ext > NW'(spanbuf_pkg::MAX_LINES)) ?
                       NW'(spanbuf_pkg::MAX_LINES) : lc_ext;
    assign bounds_ok = (left_reg <= right_reg);
    assign y_line    = LW'(y_reg);
    assign is_insert = (cmd_reg == spanbuf_pkg::CMD_INSERT);

    assign f_val    = int_rdata[2*XW-1:XW];
    assign l_val    = int_rdata[XW-1:0];
    assign a_m1     = a_reg - XW'(1);
    assign b_p1     = b_reg + XW'(1);
    assign stop_c   = (f_val > b_reg);
    assign below_c  = (l_val < a_reg);
    assign inner_c  = (f_val >= a_reg) && (l_val <= b_reg);
    assign strad_c  = (f_val < a_reg) && (l_val > b_reg);
    assign room     = {1'b0, o_reg} + {1'b0, cnt_reg} + (CW+1)'(1) - {1'b0, j_reg};
    assign ovf_need = (room > (CW+1)'(spanbuf_pkg::MAX_INTERVALS));
    assign j_p1     = j_reg + CW'(1);
    assign o_p1     = o_reg + CW'(1);
    assign new_cnt  = o_reg + cnt_reg - j_reg;
    assign full_new = full_reg | (vis_reg && (new_cnt == '0));
    assign open_after = (is_insert && vis_reg && (new_cnt == '0) && !full_reg &&
                         (open_reg != '0)) ? open_reg - NW'(1) : open_reg;

    always_comb
    begin
        priority if (stop_c)
            ev = spanbuf_pkg::EV_STOP;
        else if (below_c)
            ev = spanbuf_pkg::EV_KEEP;
        else if (inner_c)
            ev = spanbuf_pkg::EV_DROP;
        else if (strad_c)
            ev = ovf_need ? spanbuf_pkg::EV_OVF : spanbuf_pkg::EV_SPLIT;
        else if (f_val < a_reg)
            ev = spanbuf_pkg::EV_LEFT;
        else
            ev = spanbuf_pkg::EV_RIGHT;
    end

    always_comb
    begin
        line_we    = 1'b0;
        line_waddr = y_line;
        line_wdata = {full_new, new_cnt};
        unique case (op)
            spanbuf_pkg::DP_INIT:
            begin
                line_we    = 1'b1;
                line_waddr = k_reg[LW-1:0];
                line_wdata = {1'b0, CW'(1)};
            end
            spanbuf_pkg::DP_CLR:
            begin
                line_we    = 1'b1;
                line_waddr = k_reg[LW-1:0];
                line_wdata = bounds_ok ? {1'b0, CW'(1)} : {1'b1, CW'(0)};
            end
            spanbuf_pkg::DP_FIN_WALK:
            begin
                line_we = is_insert;
            end
            default:
            begin
                line_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        int_we    = 1'b0;
        int_wline = y_line;
        int_wslot = o_reg[SW-1:0];
        int_wf    = f_val;
        int_wl    = l_val;
        unique case (op)
            spanbuf_pkg::DP_CLR:
            begin
                int_we    = bounds_ok;
                int_wline = k_reg[LW-1:0];
                int_wslot = '0;
                int_wf    = XW'(left_reg);
                int_wl    = XW'(right_reg);
            end
            spanbuf_pkg::DP_IEV:
            begin
                if (is_insert)
                begin
                    unique case (ev)
                        spanbuf_pkg::EV_KEEP,
                        spanbuf_pkg::EV_OVF:   int_we = 1'b1;
                        spanbuf_pkg::EV_STOP:  int_we = (o_reg != j_reg);
                        spanbuf_pkg::EV_DROP:  int_we = 1'b0;
                        spanbuf_pkg::EV_LEFT,
                        spanbuf_pkg::EV_SPLIT:
                        begin
                            int_we = 1'b1;
                            int_wl = a_m1;
                        end
                        spanbuf_pkg::EV_RIGHT:
                        begin
                            int_we = 1'b1;
                            int_wf = b_p1;
                        end
                        default:               int_we = 1'b0;
                    endcase
                end
            end
            spanbuf_pkg::DP_TEV:
            begin
                int_we = 1'b1;
            end
            spanbuf_pkg::DP_BEV:
            begin
                int_we    = 1'b1;
                int_wslot = j_p1[SW-1:0];
            end
            spanbuf_pkg::DP_WRR,
            spanbuf_pkg::DP_WRRB:
            begin
                int_we    = 1'b1;
                int_wslot = o_p1[SW-1:0];
                int_wf    = rf_reg;
                int_wl    = rl_reg;
            end
            default:
            begin
                int_we = 1'b0;
            end
        endcase
    end

    spanbuf_ram #(
        .WIDTH(CW + 1),
        .DEPTH(spanbuf_pkg::MAX_LINES)
    ) u_line_ram (
        .clk  (clk),
        .we   (line_we),
        .waddr(line_waddr),
        .wdata(line_wdata),
        .raddr(y_line),
        .rdata(line_rdata)
    );

    spanbuf_ram #(
        .WIDTH(2 * XW),
        .DEPTH(spanbuf_pkg::MAX_LINES * spanbuf_pkg::MAX_INTERVALS)
    ) u_int_ram (
        .clk  (clk),
        .we   (int_we),
        .waddr({int_wline, int_wslot}),
        .wdata({int_wf, int_wl}),
        .raddr({y_line, j_reg[SW-1:0]}),
        .rdata(int_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= spanbuf_pkg::RST_SCREEN_LEFT;
            right_reg  <= spanbuf_pkg::RST_SCREEN_RIGHT;
            lcount_reg <= spanbuf_pkg::RST_LINE_COUNT;
            open_reg   <= NW'(spanbuf_pkg::RST_LINE_COUNT);
            k_reg      <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    spanbuf_pkg::REG_SCREEN_LEFT:  left_reg   <= cfg_data;
                    spanbuf_pkg::REG_SCREEN_RIGHT: right_reg  <= cfg_data;
                    spanbuf_pkg::REG_LINE_COUNT:   lcount_reg <= cfg_data;
                    default:                       left_reg   <= left_reg;
                endcase
            end
            if (op == spanbuf_pkg::DP_ACCEPT)
            begin
                k_reg <= '0;
            end
            else if (op == spanbuf_pkg::DP_INIT || op == spanbuf_pkg::DP_CLR)
            begin
                k_reg <= k_reg + NW'(1);
            end
            if (op == spanbuf_pkg::DP_FIN_CLR)
            begin
                open_reg <= bounds_ok ? n_use : '0;
            end
            else if (op == spanbuf_pkg::DP_FIN_WALK)
            begin
                open_reg <= open_after;
            end
            done_reg <= (op == spanbuf_pkg::DP_FIN_CLR)   ||
                        (op == spanbuf_pkg::DP_FIN_OTHER) ||
                        (op == spanbuf_pkg::DP_FIN_NOUSE) ||
                        (op == spanbuf_pkg::DP_FIN_REV)   ||
                        (op == spanbuf_pkg::DP_FIN_WALK);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            spanbuf_pkg::DP_ACCEPT:
            begin
                cmd_reg <= cmd;
                y_reg   <= line_index;
                a_reg   <= span_start;
                b_reg   <= span_end;
            end
            spanbuf_pkg::DP_LCAP:
            begin
                cnt_reg  <= line_rdata[CW-1:0];
                full_reg <= line_rdata[CW];
                j_reg    <= '0;
                o_reg    <= '0;
                vis_reg  <= 1'b0;
                ovf_reg  <= 1'b0;
            end
            spanbuf_pkg::DP_IEV:
            begin
                if (!is_insert)
                begin
                    if (ev == spanbuf_pkg::EV_KEEP)
                        j_reg <= j_p1;
                    else
                        vis_reg <= !stop_c;
                end
                else
                begin
                    unique case (ev)
                        spanbuf_pkg::EV_KEEP:
                        begin
                            o_reg <= o_p1;
                            j_reg <= j_p1;
                        end
                        spanbuf_pkg::EV_STOP:
                        begin
                            if (o_reg != j_reg)
                            begin
                                o_reg <= o_p1;
                                j_reg <= j_p1;
                            end
                        end
                        spanbuf_pkg::EV_DROP:
                        begin
                            vis_reg <= 1'b1;
                            j_reg   <= j_p1;
                        end
                        spanbuf_pkg::EV_LEFT,
                        spanbuf_pkg::EV_RIGHT:
                        begin
                            vis_reg <= 1'b1;
                            o_reg   <= o_p1;
                            j_reg   <= j_p1;
                        end
                        spanbuf_pkg::EV_OVF:
                        begin
                            vis_reg <= 1'b1;
                            ovf_reg <= 1'b1;
                            o_reg   <= o_p1;
                            j_reg   <= j_p1;
                        end
                        spanbuf_pkg::EV_SPLIT:
                        begin
                            vis_reg <= 1'b1;
                            rf_reg  <= b_p1;
                            rl_reg  <= l_val;
                            if (o_reg == j_reg)
                                j_reg <= cnt_reg - CW'(1);
                        end
                        default:
                        begin
                            vis_reg <= vis_reg;
                        end
                    endcase
                end
            end
            spanbuf_pkg::DP_TEV:
            begin
                o_reg <= o_p1;
                j_reg <= j_p1;
            end
            spanbuf_pkg::DP_BEV:
            begin
                j_reg <= j_reg - CW'(1);
            end
            spanbuf_pkg::DP_WRR:
            begin
                o_reg <= o_reg + CW'(2);
                j_reg <= j_p1;
            end
            spanbuf_pkg::DP_WRRB:
            begin
                o_reg <= cnt_reg + CW'(1);
                j_reg <= cnt_reg;
            end
            spanbuf_pkg::DP_FIN_CLR:
            begin
                res_vis_reg   <= 1'b0;
                res_full_reg  <= 1'b0;
                res_count_reg <= bounds_ok ? n_use : '0;
                res_ovf_reg   <= 1'b0;
            end
            spanbuf_pkg::DP_FIN_OTHER:
            begin
                res_vis_reg   <= 1'b0;
                res_full_reg  <= 1'b0;
                res_count_reg <= open_reg;
                res_ovf_reg   <= 1'b0;
            end
            spanbuf_pkg::DP_FIN_NOUSE:
            begin
                res_vis_reg   <= 1'b0;
                res_full_reg  <= 1'b1;
                res_count_reg <= open_reg;
                res_ovf_reg   <= 1'b0;
            end
            spanbuf_pkg::DP_FIN_REV:
            begin
                res_vis_reg   <= 1'b0;
                res_full_reg  <= full_reg;
                res_count_reg <= open_reg;
                res_ovf_reg   <= 1'b0;
            end
            spanbuf_pkg::DP_FIN_WALK:
            begin
                res_vis_reg   <= vis_reg;
                res_full_reg  <= is_insert ? full_new : full_reg;
                res_count_reg <= open_after;
                res_ovf_reg   <= ovf_reg;
            end
            default:
            begin
                res_vis_reg <= res_vis_reg;
            end
        endcase
    end

    always_comb
    begin
        status.cmd       = cmd_reg;
        status.in_use    = (NW'(y_reg) < n_use);
        status.span_rev  = (a_reg > b_reg);
        status.init_last = (k_reg == NW'(spanbuf_pkg::MAX_LINES - 1));
        status.clr_end   = (k_reg == n_use);
        status.j_eq_cnt  = (j_reg == cnt_reg);
        status.j_eq_o    = (j_reg == o_reg);
        status.o1_eq_j   = (o_p1 == j_reg);
        status.ev        = ev;
    end

    assign done           = done_reg;
    assign visible        = res_vis_reg;
    assign line_now_full  = res_full_reg;
    assign lines_not_full = spanbuf_pkg::CFG_W'(res_count_reg);
    assign overflow       = res_ovf_reg;

endmodule

// ----- rtl/coverage_span_buffer.sv -----
// Top level of the coverage span buffer: controller plus datapath.
// Depends on spanbuf_pkg, spanbuf_ctrl, spanbuf_dp, coverage_span_buffer_defines.svh.
//
// Usage:
//   Command channel: a word (cmd, line_index, span_start, span_end) is taken
//   at a clock edge with start high and busy low. One result word comes back
//   per command on visible, line_now_full, lines_not_full and overflow,
//   valid for the single cycle that done is high; the receiver cannot stall.
//   Configuration: cfg_we writes cfg_data to register cfg_index
//   (0 screen_left, 1 screen_right, 2 line_count) at once; write while idle.
// Command flow (start to done, one command at a time):
//   clear: the lines in use are written one line per cycle.
//   test: each interval is read and evaluated in turn until the span is
//   decided or the walk runs off the end of the list; a reversed span
//   ends without a walk. insert: as test, plus moving intervals when a stop,
//   overflow or split leaves a gap or shifts the tail, plus writing the
//   right half of a split.
//   Unused commands and lines out of range end without a walk.
// Reset: a clearing pass over all 1024 lines sets every line to one interval and
//   not full; busy stays high meanwhile. Interval contents are undefined
//   until the first clear.
`timescale 1ns / 1ps
`include "coverage_span_buffer_defines.svh"

module coverage_span_buffer (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    output logic                                      busy,
    input  logic [1:0]                                cmd,
    input  logic [spanbuf_pkg::LIDX_W-1:0]            line_index,
    input  logic signed [spanbuf_pkg::COORD_BITS-1:0] span_start,
    input  logic signed [spanbuf_pkg::COORD_BITS-1:0] span_end,
    output logic                                      done,
    output logic                                      visible,
    output logic                                      line_now_full,
    output logic [spanbuf_pkg::CFG_W-1:0]             lines_not_full,
    output logic                                      overflow,
    input  logic                                      cfg_we,
    input  logic [1:0]                                cfg_index,
    input  logic [spanbuf_pkg::CFG_W-1:0]             cfg_data
);

    spanbuf_pkg::dp_op_t     dp_op;
    spanbuf_pkg::sb_status_t dp_status;

    spanbuf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .status(dp_status),
        .op    (dp_op),
        .busy  (busy)
    );

    spanbuf_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (dp_op),
        .status        (dp_status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .line_index    (line_index),
        .span_start    (span_start),
        .span_end      (span_end),
        .done          (done),
        .visible       (visible),
        .line_now_full (line_now_full),
        .lines_not_full(lines_not_full),
        .overflow      (overflow)
    );

    `SB_ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
    `SB_ASSERT_CLK(a_done_pulse, done |=> !done, "done held for more than one cycle")
    `SB_ASSERT_CLK(a_ovf_vis, (done && overflow) |-> visible, "overflow without visible span")
    `SB_ASSERT_CLK(a_count_max, done |-> (lines_not_full <= spanbuf_pkg::OPEN_MAX), "count high")

endmodule

// ----- tb/tb_coverage_span_buffer.sv -----
// Self-checking testbench for coverage_span_buffer: drives commands and register
// writes, predicts every result word with a scoreboard class and compares them.
// Depends on spanbuf_pkg and the coverage_span_buffer RTL.
`timescale 1ns / 1ps

module tb_coverage_span_buffer;
    import spanbuf_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic                 vis;
        logic                 full;
        logic [CFG_W-1:0]     open_lines;
        logic                 ovf;
    } span_result_t;

    class span_scoreboard;
        int first_x [MAX_LINES][MAX_INTERVALS];
        int last_x [MAX_LINES][MAX_INTERVALS];
        int span_cnt [MAX_LINES];
        bit line_full [MAX_LINES];
        int open_lines;
        int scr_left;
        int scr_right;
        int lcount;
        int errors;
        span_result_t pending[$];

        function new();
            scr_left = int'(RST_SCREEN_LEFT);
            scr_right = int'(RST_SCREEN_RIGHT);
            lcount = int'(RST_LINE_COUNT);
            for (int y = 0; y < MAX_LINES; y++)
            begin
                span_cnt[y] = 1;
                line_full[y] = 0;
            end
            open_lines = lcount;
            errors = 0;
        endfunction

        function int lines_used();
            return (lcount > MAX_LINES) ? MAX_LINES : lcount;
        endfunction

        function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] v);
            if (idx == REG_SCREEN_LEFT)
                scr_left = int'(v);
            else if (idx == REG_SCREEN_RIGHT)
                scr_right = int'(v);
            else if (idx == REG_LINE_COUNT)
                lcount = int'(v);
        endfunction

        function bit test_span(int y, int a, int b);
            for (int i = 0; i < span_cnt[y]; i++)
            begin
                if (a <= last_x[y][i])
                    return first_x[y][i] <= b;
            end
            return 0;
        endfunction

        function bit cover_span(int y, int a, int b, ref bit ovf);
            int nf [MAX_INTERVALS];
            int nl [MAX_INTERVALS];
            int cnt;
            int o;
            int f;
            int l;
            bit vis;
            bit stop;
            cnt = span_cnt[y];
            o = 0;
            vis = 0;
            stop = 0;
            for (int i = 0; i < cnt; i++)
            begin
                f = first_x[y][i];
                l = last_x[y][i];
                if (!stop && f > b)
                    stop = 1;
                if (stop || l < a)
                begin
                    nf[o] = f; nl[o] = l; o++;
                    continue;
                end
                vis = 1;
                if (f >= a && l <= b)
                    continue;
                if (f < a && l > b)
                begin
                    if (o + 2 + (cnt - i - 1) > MAX_INTERVALS)
                    begin
                        ovf = 1;
                        nf[o] = f; nl[o] = l; o++;
                    end
                    else
                    begin
                        nf[o] = f; nl[o] = a - 1; o++;
                        nf[o] = b + 1; nl[o] = l; o++;
                    end
                    stop = 1;
                end
                else if (f < a)
                begin
                    nf[o] = f; nl[o] = a - 1; o++;
                end
                else
                begin
                    nf[o] = b + 1; nl[o] = l; o++;
                end
            end
            for (int i = 0; i < o; i++)
            begin
                first_x[y][i] = nf[i];
                last_x[y][i] = nl[i];
            end
            span_cnt[y] = o;
            return vis;
        endfunction

        function void note_command(logic [1:0] c, int y, int a, int b);
            span_result_t r;
            bit ovf;
            int n;
            r.vis = 0;
            r.full = 0;
            ovf = 0;
            if (c == CMD_CLEAR)
            begin
                n = lines_used();
                for (int k = 0; k < n; k++)
                begin
                    if (scr_left <= scr_right)
                    begin
                        first_x[k][0] = scr_left;
                        last_x[k][0] = scr_right;
                        span_cnt[k] = 1;
                        line_full[k] = 0;
                    end
                    else
                    begin
                        span_cnt[k] = 0;
                        line_full[k] = 1;
                    end
                end
                open_lines = (scr_left <= scr_right) ? n : 0;
            end
            else if (c == CMD_TEST || c == CMD_INSERT)
            begin
                if (y >= lines_used())
                    r.full = 1;
                else
                begin
                    if (a <= b)
                    begin
                        if (c == CMD_TEST)
                            r.vis = test_span(y, a, b);
                        else
                        begin
                            r.vis = cover_span(y, a, b, ovf);
                            if (r.vis && span_cnt[y] == 0 && !line_full[y])
                            begin
                                line_full[y] = 1;
                                if (open_lines > 0)
                                    open_lines--;
                            end
                        end
                    end
                    r.full = line_full[y];
                end
            end
            r.open_lines = CFG_W'(open_lines);
            r.ovf = ovf;
            pending.push_back(r);
        endfunction

        function void check_result(logic vis, logic full, logic [CFG_W-1:0] nf, logic ovf);
            span_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word vis=%0b full=%0b count=%0d ovf=%0b",
                         $time, vis, full, nf, ovf);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (vis !== e.vis)
            begin
                $display("%0t: visible expected %0b actual %0b", $time, e.vis, vis);
                errors++;
            end
            if (full !== e.full)
            begin
                $display("%0t: line_now_full expected %0b actual %0b", $time, e.full, full);
                errors++;
            end
            if (nf !== e.open_lines)
            begin
                $display("%0t: lines_not_full expected %0d actual %0d", $time,
                         e.open_lines, nf);
                errors++;
            end
            if (ovf !== e.ovf)
            begin
                $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic [1:0] cmd = CMD_UNUSED;
    logic [LIDX_W-1:0] line_index = '0;
    logic signed [COORD_BITS-1:0] span_start = '0;
    logic signed [COORD_BITS-1:0] span_end = '0;
    logic done;
    logic visible;
    logic line_now_full;
    logic [CFG_W-1:0] lines_not_full;
    logic overflow;
    logic cfg_we = 0;
    logic [1:0] cfg_index = REG_SCREEN_LEFT;
    logic [CFG_W-1:0] cfg_data = '0;

    span_scoreboard span_sb = new();

    coverage_span_buffer dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .line_index(line_index), .span_start(span_start), .span_end(span_end),
        .done(done), .visible(visible), .line_now_full(line_now_full),
        .lines_not_full(lines_not_full), .overflow(overflow),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            span_sb.check_result(visible, line_now_full, lines_not_full, overflow);
    end

    task automatic send_word(logic [1:0] c, int y, int a, int b);
        @(negedge clk);
        start = 1;
        cmd = c;
        line_index = LIDX_W'(y);
        span_start = COORD_BITS'(a);
        span_end = COORD_BITS'(b);
        do
            @(posedge clk);
        while (busy);
        span_sb.note_command(c, int'(line_index), int'(span_start), int'(span_end));
    endtask

    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            start = 0;
        end
    endtask

    task automatic drain();
        idle_cycles(1);
        while (span_sb.pending.size() != 0)
            @(posedge clk);
        idle_cycles(20);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = v;
        span_sb.write_reg(idx, v);
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic set_screen(int l, int r, int n);
        drain();
        write_cfg(REG_SCREEN_LEFT, CFG_W'(l));
        write_cfg(REG_SCREEN_RIGHT, CFG_W'(r));
        write_cfg(REG_LINE_COUNT, CFG_W'(n));
        send_word(CMD_CLEAR, 0, 0, 0);
    endtask

    task automatic random_word();
        logic [1:0] c;
        int y;
        int a;
        int b;
        int p;
        int used;
        p = $urandom_range(0, 99);
        if (p < 2)
            c = CMD_CLEAR;
        else if (p < 30)
            c = CMD_TEST;
        else if (p < 95)
            c = CMD_INSERT;
        else
            c = CMD_UNUSED;
        used = span_sb.lines_used();
        if ($urandom_range(0, 9) == 0)
            y = $urandom_range(0, 1023);
        else
            y = $urandom_range(0, (used + 1 > 1023) ? 1023 : used + 1);
        if ($urandom_range(0, 9) < 7)
        begin
            a = $urandom_range(0, span_sb.scr_right + 10) - 5;
            b = a + $urandom_range(0, 8);
            if ($urandom_range(0, 19) == 0)
                b = a - $urandom_range(1, 4);
            if (a > 2047) a = 2047;
            if (b > 2047) b = 2047;
        end
        else
        begin
            a = $signed(12'($urandom));
            b = $signed(12'($urandom));
        end
        send_word(c, y, a, b);
    endtask

    task automatic random_phase(int n, int pct);
        for (int i = 0; i < n; i++)
        begin
            while ($urandom_range(0, 99) < pct)
                idle_cycles(1);
            random_word();
        end
    endtask

    initial
    begin
        #50000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        set_screen(0, 2047, 1024);
        send_word(CMD_TEST, 3, -2048, 2047);
        send_word(CMD_INSERT, 3, 100, 200);
        send_word(CMD_TEST, 3, 150, 160);
        send_word(CMD_TEST, 3, 99, 100);
        send_word(CMD_INSERT, 3, -2048, 10);
        send_word(CMD_INSERT, 3, 2000, 2047);
        send_word(CMD_INSERT, 3, 300, 250);
        send_word(CMD_INSERT, 3, -2048, 2047);
        send_word(CMD_TEST, 3, 0, 2047);
        send_word(CMD_INSERT, 1023, 0, 5);
        send_word(CMD_UNUSED, 5, 0, 5);
        send_word(CMD_TEST, 5, 2047, -2048);
        set_screen(2047, 2047, 1);
        send_word(CMD_INSERT, 0, 2047, 2047);
        send_word(CMD_INSERT, 1, 0, 0);
        set_screen(100, 50, 7);
        send_word(CMD_TEST, 2, 0, 2047);
        send_word(CMD_INSERT, 2, 0, 2047);

        set_screen(0, 2047, 2);
        random_phase(400, 29);
        set_screen(0, 150, 7);
        random_phase(200, 81);
        drain();
        set_screen(10, 400, 300);
        random_phase(200, 81);
        set_screen(0, 639, 1);
        random_phase(400, 0);
        drain();

        if (span_sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
